/* rtl/ffa_pkg.sv */
package ffa_pkg;

    // Field widths
    localparam int SIZE_W = 25;
    localparam int OFF_W  = 24;
    localparam int NEED_W = 26;
    localparam int STAT_W = 3;

    // Defaults and limits
    localparam int FRAGMENTS_DEF = 64;
    localparam logic [SIZE_W-1:0] POOL_RESET = 25'd1048576;
    localparam logic [SIZE_W-1:0] POOL_MAX   = 25'd16777216;
    localparam logic [NEED_W-1:0] ALIGN_MASK = 26'd7;

    // Request codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_ZERO_SIZE = 3'd1,
        STAT_POOL_FULL = 3'd2,
        STAT_TABLE_FULL = 3'd3,
        STAT_NO_FRAG   = 3'd4
    } status_t;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_RESP
    } fsm_state_t;

    // One fragment table entry
    typedef struct packed {
        logic [OFF_W-1:0]  start;
        logic [SIZE_W-1:0] size;
        logic              used;
    } frag_entry_t;

endpackage

/* rtl/first_fit_fragment_allocator_unit.sv */
// First-fit fragment allocator. Keeps a table of up to FRAGMENTS fragments
// (start offset, size, used mark) in a single-port-read, single-port-write
// memory, plus an append point and a running count of bytes in use. An
// allocate beat rounds its size up to a multiple of 8 and takes the first
// free fragment large enough, whole; failing that it appends a new fragment,
// unless the pool (pool_size, clamped to 16 MiB) or the table is full. A free
// beat releases the used fragment starting at req_offset. Each request
// returns one result beat with status, granted offset, bytes used and bytes
// free. The table is walked one entry per cycle through the memory read
// port, and an allocate that finds no free fragment large enough goes on
// to the append check. A new request is taken once the previous result
// sits in the output register. Write pool_size only while the block is
// idle.
module first_fit_fragment_allocator_unit #(
    parameter int FRAGMENTS = ffa_pkg::FRAGMENTS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ffa_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [ffa_pkg::SIZE_W-1:0]   req_size,
    input  logic [ffa_pkg::OFF_W-1:0]    req_offset,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ffa_pkg::STAT_W-1:0]   status,
    output logic [ffa_pkg::OFF_W-1:0]    grant_offset,
    output logic [ffa_pkg::SIZE_W-1:0]   used_bytes,
    output logic [ffa_pkg::SIZE_W-1:0]   free_bytes
);
    import ffa_pkg::*;

    localparam int IDX_W = (FRAGMENTS > 1) ? $clog2(FRAGMENTS) : 1;
    localparam int CNT_W = $clog2(FRAGMENTS + 1);

    logic [SIZE_W-1:0] pool_size_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  wr_addr;
    logic              wr_en;
    frag_entry_t       rd_data;
    frag_entry_t       wr_data;

    // Pool size register, written through the config channel
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_size_reg <= POOL_RESET;
        end
        else if (cfg_valid)
        begin
            pool_size_reg <= cfg_data;
        end
    end

    // Fragment table memory
    ffa_table #(
        .FRAGMENTS (FRAGMENTS),
        .IDX_W     (IDX_W)
    ) u_table (
        .clk     (clk),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // Request sequencer and output register
    ffa_ctrl #(
        .FRAGMENTS (FRAGMENTS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pool_size    (pool_size_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .req_size     (req_size),
        .req_offset   (req_offset),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .grant_offset (grant_offset),
        .used_bytes   (used_bytes),
        .free_bytes   (free_bytes),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

endmodule

/* rtl/ffa_table.sv */
module ffa_table #(
    parameter int FRAGMENTS = ffa_pkg::FRAGMENTS_DEF,
    parameter int IDX_W     = $clog2(FRAGMENTS)
) (
    input  logic                 clk,
    input  logic [IDX_W-1:0]     rd_addr,
    output ffa_pkg::frag_entry_t rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ffa_pkg::frag_entry_t wr_data
);
    import ffa_pkg::*;

    // Fragment table storage, one read and one write port
    frag_entry_t mem [FRAGMENTS];
    frag_entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ffa_ctrl.sv */
module ffa_ctrl #(
    parameter int FRAGMENTS = ffa_pkg::FRAGMENTS_DEF,
    parameter int IDX_W     = $clog2(FRAGMENTS),
    parameter int CNT_W     = $clog2(FRAGMENTS + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [ffa_pkg::SIZE_W-1:0]   pool_size,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic [ffa_pkg::SIZE_W-1:0]   req_size,
    input  logic [ffa_pkg::OFF_W-1:0]    req_offset,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ffa_pkg::STAT_W-1:0]   status,
    output logic [ffa_pkg::OFF_W-1:0]    grant_offset,
    output logic [ffa_pkg::SIZE_W-1:0]   used_bytes,
    output logic [ffa_pkg::SIZE_W-1:0]   free_bytes,
    output logic [IDX_W-1:0]             rd_addr,
    input  ffa_pkg::frag_entry_t         rd_data,
    output logic                         wr_en,
    output logic [IDX_W-1:0]             wr_addr,
    output ffa_pkg::frag_entry_t         wr_data
);
    import ffa_pkg::*;

    // Control state
    fsm_state_t          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [SIZE_W-1:0]   append_reg, append_next;
    logic [SIZE_W-1:0]   used_reg, used_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic                out_valid_reg, out_valid_next;

    // Request and result holding
    logic                func_reg, func_next;
    logic [NEED_W-1:0]   need_reg, need_next;
    logic [OFF_W-1:0]    offset_reg, offset_next;
    status_t             res_status_reg, res_status_next;
    logic [OFF_W-1:0]    res_grant_reg, res_grant_next;

    // Output beat registers
    logic [STAT_W-1:0]   status_reg, status_next;
    logic [OFF_W-1:0]    grant_reg, grant_next;
    logic [SIZE_W-1:0]   used_out_reg, used_out_next;
    logic [SIZE_W-1:0]   free_out_reg, free_out_next;

    logic [SIZE_W-1:0]   pool_eff;
    logic [NEED_W:0]     tail_end;
    logic                hit_alloc;
    logic                hit_free;
    logic                last_entry;
    logic [CNT_W-1:0]    idx_inc;

    assign pool_eff  = (pool_size > POOL_MAX) ? POOL_MAX : pool_size;
    assign tail_end  = {2'b00, append_reg} + {1'b0, need_reg};
    assign idx_inc   = CNT_W'(idx_reg) + CNT_W'(1);
    assign last_entry = (idx_inc == count_reg);
    assign hit_alloc = (func_reg == FUNC_ALLOC) && !rd_data.used
                       && ({1'b0, rd_data.size} >= need_reg);
    assign hit_free  = (func_reg == FUNC_FREE) && rd_data.used
                       && (rd_data.start == offset_reg);

    // Read the entry after the one being checked; entry 0 while idle
    assign rd_addr = (state_reg == S_SCAN) ? IDX_W'(idx_inc) : '0;

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign grant_offset = grant_reg;
    assign used_bytes   = used_out_reg;
    assign free_bytes   = free_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            append_reg    <= '0;
            used_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            append_reg    <= append_next;
            used_reg      <= used_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        need_reg       <= need_next;
        offset_reg     <= offset_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        status_reg     <= status_next;
        grant_reg      <= grant_next;
        used_out_reg   <= used_out_next;
        free_out_reg   <= free_out_next;
    end

    // Sequencer: accept, walk the table, append, deliver
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        append_next     = append_reg;
        used_next       = used_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg;
        func_next       = func_reg;
        need_next       = need_reg;
        offset_next     = offset_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        status_next     = status_reg;
        grant_next      = grant_reg;
        used_out_next   = used_out_reg;
        free_out_next   = free_out_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = rd_data;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next      = func;
                    need_next      = ({1'b0, req_size} + ALIGN_MASK) & ~ALIGN_MASK;
                    offset_next    = req_offset;
                    idx_next       = '0;
                    res_grant_next = '0;
                    if ((func == FUNC_ALLOC) && (req_size == '0))
                    begin
                        res_status_next = STAT_ZERO_SIZE;
                        state_next      = S_RESP;
                    end
                    else if (count_reg == '0)
                    begin
                        res_status_next = STAT_NO_FRAG;
                        state_next      = (func == FUNC_ALLOC) ? S_TAIL : S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit_alloc)
                begin
                    wr_en           = 1'b1;
                    wr_data.used    = 1'b1;
                    used_next       = used_reg + rd_data.size;
                    res_status_next = STAT_OK;
                    res_grant_next  = rd_data.start;
                    state_next      = S_RESP;
                end
                else if (hit_free)
                begin
                    wr_en           = 1'b1;
                    wr_data.used    = 1'b0;
                    used_next       = (used_reg >= rd_data.size)
                                      ? used_reg - rd_data.size : '0;
                    res_status_next = STAT_OK;
                    state_next      = S_RESP;
                end
                else if (last_entry)
                begin
                    res_status_next = STAT_NO_FRAG;
                    state_next      = (func_reg == FUNC_ALLOC) ? S_TAIL : S_RESP;
                end
                else
                begin
                    idx_next = IDX_W'(idx_inc);
                end
            end

            S_TAIL:
            begin
                state_next = S_RESP;
                if (tail_end > {2'b00, pool_eff})
                begin
                    res_status_next = STAT_POOL_FULL;
                end
                else if (count_reg == CNT_W'(FRAGMENTS))
                begin
                    res_status_next = STAT_TABLE_FULL;
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_addr         = IDX_W'(count_reg);
                    wr_data.start   = append_reg[OFF_W-1:0];
                    wr_data.size    = need_reg[SIZE_W-1:0];
                    wr_data.used    = 1'b1;
                    count_next      = count_reg + CNT_W'(1);
                    append_next     = append_reg + need_reg[SIZE_W-1:0];
                    used_next       = used_reg + need_reg[SIZE_W-1:0];
                    res_status_next = STAT_OK;
                    res_grant_next  = append_reg[OFF_W-1:0];
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    grant_next     = res_grant_reg;
                    used_out_next  = used_reg;
                    free_out_next  = (pool_eff > used_reg) ? pool_eff - used_reg : '0;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* tb/first_fit_fragment_allocator_checker.sv */
`timescale 1ns / 1ps

module first_fit_fragment_allocator_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [ffa_pkg::SIZE_W-1:0]   cfg_data,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         func,
    input  logic [ffa_pkg::SIZE_W-1:0]   req_size,
    input  logic [ffa_pkg::OFF_W-1:0]    req_offset,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [ffa_pkg::STAT_W-1:0]   status,
    input  logic [ffa_pkg::OFF_W-1:0]    grant_offset,
    input  logic [ffa_pkg::SIZE_W-1:0]   used_bytes,
    input  logic [ffa_pkg::SIZE_W-1:0]   free_bytes,
    output int                           fail_count,
    output int                           outstanding
);

    import ffa_pkg::*;

    localparam int FRAG_DEPTH = FRAGMENTS_DEF;

    typedef struct {
        status_t           stat;
        logic [OFF_W-1:0]  grant;
        logic [SIZE_W-1:0] used;
        logic [SIZE_W-1:0] spare;
    } alloc_beat_t;

    // Shadow copy of the fragment table and pool register
    logic [SIZE_W-1:0] pool_cfg;
    logic [OFF_W-1:0]  frag_start [FRAG_DEPTH];
    logic [SIZE_W-1:0] frag_size  [FRAG_DEPTH];
    logic              frag_used  [FRAG_DEPTH];
    int                frag_cnt;
    logic [SIZE_W-1:0] append_pt;
    logic [SIZE_W-1:0] used_sum;

    alloc_beat_t expected_beats[$];
    int          mismatches = 0;

    // Apply one request to the shadow table and return the result it earns
    function automatic alloc_beat_t serve_request(input logic f,
                                                  input logic [SIZE_W-1:0] sz,
                                                  input logic [OFF_W-1:0] off);
        alloc_beat_t       r;
        logic [NEED_W-1:0] need;
        logic [SIZE_W-1:0] pool;
        logic [SIZE_W+1:0] tail;
        int                hit;
        r.stat  = STAT_OK;
        r.grant = '0;
        hit     = -1;
        pool    = (pool_cfg > POOL_MAX) ? POOL_MAX : pool_cfg;
        if (f == FUNC_ALLOC) begin
            if (sz == '0) begin
                r.stat = STAT_ZERO_SIZE;
            end
            else begin
                need = ({1'b0, sz} + ALIGN_MASK) & ~ALIGN_MASK;
                // first free fragment big enough, taken whole
                for (int k = 0; k < frag_cnt; k++) begin
                    if (hit < 0 && !frag_used[k] && {1'b0, frag_size[k]} >= need)
                        hit = k;
                end
                tail = {2'b00, append_pt} + {1'b0, need};
                if (hit >= 0) begin
                    frag_used[hit] = 1'b1;
                    used_sum       = used_sum + frag_size[hit];
                    r.grant        = frag_start[hit];
                end
                else if (tail > {2'b00, pool}) begin
                    r.stat = STAT_POOL_FULL;
                end
                else if (frag_cnt >= FRAG_DEPTH) begin
                    r.stat = STAT_TABLE_FULL;
                end
                else begin
                    frag_start[frag_cnt] = append_pt[OFF_W-1:0];
                    frag_size[frag_cnt]  = need[SIZE_W-1:0];
                    frag_used[frag_cnt]  = 1'b1;
                    r.grant              = append_pt[OFF_W-1:0];
                    frag_cnt             = frag_cnt + 1;
                    append_pt            = append_pt + need[SIZE_W-1:0];
                    used_sum             = used_sum + need[SIZE_W-1:0];
                end
            end
        end
        else begin
            for (int k = 0; k < frag_cnt; k++) begin
                if (hit < 0 && frag_used[k] && frag_start[k] == off)
                    hit = k;
            end
            if (hit >= 0) begin
                frag_used[hit] = 1'b0;
                used_sum = (used_sum >= frag_size[hit]) ? used_sum - frag_size[hit] : '0;
            end
            else begin
                r.stat = STAT_NO_FRAG;
            end
        end
        r.used  = used_sum;
        r.spare = (pool > used_sum) ? pool - used_sum : '0;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [SIZE_W-1:0] want_v,
                               input logic [SIZE_W-1:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want_v, got_v);
            mismatches++;
        end
    endtask

    // Watch all three channels; result beats are retired before new requests
    always @(posedge clk or negedge rst_n) begin : watch
        alloc_beat_t want;
        if (!rst_n) begin
            pool_cfg  = POOL_RESET;
            frag_cnt  = 0;
            append_pt = '0;
            used_sum  = '0;
            for (int k = 0; k < FRAG_DEPTH; k++)
                frag_used[k] = 1'b0;
            expected_beats.delete();
            outstanding <= 0;
        end
        else begin
            if (out_valid && out_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected result beat: expected none, got status %0d",
                             $time, status);
                    mismatches++;
                end
                else begin
                    want = expected_beats.pop_front();
                    check_field("status", SIZE_W'(want.stat), SIZE_W'(status));
                    check_field("grant_offset", SIZE_W'(want.grant), SIZE_W'(grant_offset));
                    check_field("used_bytes", want.used, used_bytes);
                    check_field("free_bytes", want.spare, free_bytes);
                end
            end
            if (in_valid && in_ready)
                expected_beats.push_back(serve_request(func, req_size, req_offset));
            if (cfg_valid && cfg_ready)
                pool_cfg = cfg_data;
            outstanding <= expected_beats.size();
            fail_count  <= mismatches;
        end
    end

endmodule

/* tb/first_fit_fragment_allocator_unit_tb.sv */
`timescale 1ns / 1ps

module first_fit_fragment_allocator_unit_tb;

    import ffa_pkg::*;

    localparam int SETTLE      = FRAGMENTS_DEF + 10;
    localparam int PHASE_ITEMS = 235;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [SIZE_W-1:0]   cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                func       = FUNC_ALLOC;
    logic [SIZE_W-1:0]   req_size   = '0;
    logic [OFF_W-1:0]    req_offset = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [STAT_W-1:0]   status;
    logic [OFF_W-1:0]    grant_offset;
    logic [SIZE_W-1:0]   used_bytes;
    logic [SIZE_W-1:0]   free_bytes;
    int                  fail_count;
    int                  outstanding;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    // Offsets believed live, fed from granted allocations; recently freed ones
    logic [OFF_W-1:0] live_offsets[$];
    logic [OFF_W-1:0] freed_offsets[$];
    logic             funcs_in_flight[$];

    first_fit_fragment_allocator_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .req_size(req_size), .req_offset(req_offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .grant_offset(grant_offset),
        .used_bytes(used_bytes), .free_bytes(free_bytes)
    );

    first_fit_fragment_allocator_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .func(func), .req_size(req_size), .req_offset(req_offset),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .grant_offset(grant_offset),
        .used_bytes(used_bytes), .free_bytes(free_bytes),
        .fail_count(fail_count), .outstanding(outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver back-pressure
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= rx_stall_pct);

    // Track granted offsets so frees can name real fragments
    always @(posedge clk) begin
        if (out_valid && out_ready && funcs_in_flight.size() > 0) begin
            if (funcs_in_flight.pop_front() == FUNC_ALLOC && status == STAT_OK)
                live_offsets.push_back(grant_offset);
        end
        if (in_valid && in_ready)
            funcs_in_flight.push_back(func);
    end

    task automatic send_req(input logic f, input logic [SIZE_W-1:0] sz,
                            input logic [OFF_W-1:0] off);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        req_size   <= sz;
        req_offset <= off;
        do @(posedge clk); while (!in_ready);
    endtask

    // Hold off until every result beat is back, then let the block settle
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_pool(input logic [SIZE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Mostly allocs and frees of live fragments; some double frees and noise
    task automatic random_item();
        int               pick;
        int               sel;
        int               idx;
        logic [SIZE_W-1:0] sz;
        logic [OFF_W-1:0]  off;
        pick = $urandom_range(99);
        sz   = SIZE_W'($urandom);
        off  = OFF_W'($urandom);
        if (pick < 50) begin
            sel = $urandom_range(99);
            if (sel < 3)
                sz = '0;
            else if (sel < 20)
                sz = SIZE_W'($urandom_range(1, 65536));
            else if (sel >= 27)
                sz = SIZE_W'($urandom_range(1, 256));
            send_req(FUNC_ALLOC, sz, off);
        end
        else if (pick < 88 && live_offsets.size() > 0) begin
            idx = $urandom_range(live_offsets.size() - 1);
            off = live_offsets[idx];
            live_offsets.delete(idx);
            freed_offsets.push_back(off);
            if (freed_offsets.size() > 8)
                void'(freed_offsets.pop_front());
            send_req(FUNC_FREE, sz, off);
        end
        else if (pick < 94 && freed_offsets.size() > 0) begin
            off = freed_offsets[$urandom_range(freed_offsets.size() - 1)];
            send_req(FUNC_FREE, sz, off);
        end
        else begin
            send_req(FUNC_FREE, sz, off);
        end
    endtask

    logic [SIZE_W-1:0] pool_plan [8];
    int                tx_plan   [4] = '{0, 70, 0, 17};
    int                rx_plan   [4] = '{0, 0, 70, 17};

    initial begin
        pool_plan = '{POOL_MAX, 25'd4096, POOL_RESET, 25'h1FFFFFF, 25'd8, 25'd0,
                      SIZE_W'($urandom_range(8, 16777216)), 25'd65536};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: rounding, reuse whole, bad frees, pool edges
        send_req(FUNC_ALLOC, 25'd0, '0);          // zero size
        send_req(FUNC_ALLOC, 25'd1, '0);          // @0, rounds to 8
        send_req(FUNC_ALLOC, 25'd8, '0);          // @8
        send_req(FUNC_ALLOC, 25'd9, '0);          // @16, rounds to 16
        send_req(FUNC_FREE, '0, 24'd8);
        send_req(FUNC_FREE, '0, 24'd8);           // already free
        send_req(FUNC_FREE, '0, 24'd12345);       // unknown offset
        send_req(FUNC_ALLOC, 25'd5, '0);          // reuses @8
        send_req(FUNC_FREE, '0, 24'd16);
        send_req(FUNC_ALLOC, 25'd3, '0);          // reuses @16, counts all 16
        send_req(FUNC_ALLOC, 25'h1FFFFFF, '0);    // pool exhausted
        send_req(FUNC_ALLOC, 25'd16777216, '0);   // pool exhausted
        send_req(FUNC_ALLOC, 25'd1048544, '0);    // exact fit to pool end
        send_req(FUNC_ALLOC, 25'd8, '0);          // pool exhausted, free_bytes 0
        send_req(FUNC_FREE, '0, 24'hFFFFFF);
        send_req(FUNC_FREE, '0, 24'd32);
        send_req(FUNC_ALLOC, 25'd1, '0);          // reuses big fragment whole
        send_req(FUNC_FREE, '0, 24'd32);
        send_req(FUNC_FREE, '0, 24'd0);
        send_req(FUNC_ALLOC, 25'd8, '0);          // first fit picks @0
        send_req(FUNC_FREE, 25'h1FFFFFF, 24'd0);  // size ignored on free
        send_req(FUNC_ALLOC, 25'd7, 24'hFFFFFF);  // offset ignored on alloc

        // Random phases, each under its own pool size, with four idling mixes taken in turn
        for (int p = 0; p < 8; p++) begin
            drain_results();
            write_pool(pool_plan[p]);
            tx_idle_pct  = tx_plan[p % 4];
            rx_stall_pct = rx_plan[p % 4];
            repeat (PHASE_ITEMS) random_item();
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/ffa_pkg.sv
rtl/ffa_table.sv
rtl/ffa_ctrl.sv
rtl/first_fit_fragment_allocator_unit.sv
tb/first_fit_fragment_allocator_checker.sv
tb/first_fit_fragment_allocator_unit_tb.sv
